// ===== hw/rtl/i2cs_pkg.sv =====
// Shared types and codes for the I2C master transfer sequencer.
package i2cs_pkg;

    typedef enum logic [2:0] {
        OP_BEGIN         = 3'd0,
        OP_NONE          = 3'd1,
        OP_START_SENT    = 3'd2,
        OP_ADDR_ACKED    = 3'd3,
        OP_BYTE_RECEIVED = 3'd4,
        OP_BYTE_SENT     = 3'd5,
        OP_RESTART       = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_BUSY = 2'd1,
        ST_DONE = 2'd2
    } status_t;

    localparam logic [1:0] ACK_NO_CHANGE = 2'd0;
    localparam logic [1:0] ACK_ENABLE    = 2'd1;
    localparam logic [1:0] ACK_DISABLE   = 2'd2;

    typedef struct packed {
        logic [2:0]  op;
        logic        bus_free;
        logic        direction;
        logic [6:0]  device_address;
        logic [7:0]  register_index;
        logic [15:0] byte_count;
        logic [7:0]  received_byte;
        logic [7:0]  next_tx_byte;
    } item_t;

    typedef struct packed {
        logic        begin_accepted;
        logic        send_valid;
        logic [7:0]  send_byte;
        logic        tx_consumed;
        logic [1:0]  ack_control;
        logic        issue_start;
        logic        issue_stop;
        logic        issue_restart;
        logic        store_valid;
        logic [7:0]  store_byte;
        logic [1:0]  transfer_status;
    } result_t;

endpackage

// ===== hw/rtl/i2c_master_transfer_sequencer_core.sv =====
// Top level of the I2C master register-transfer sequencer.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_stall  | op, bus_free, direction, device_address,
//          |                      | register_index, byte_count, received_byte,
//          |                      | next_tx_byte
//  out     | out_valid / out_stall| begin_accepted, send_valid, send_byte,
//          |                      | tx_consumed, ack_control, issue_start,
//          |                      | issue_stop, issue_restart, store_valid,
//          |                      | store_byte, transfer_status
//
// Each accepted transaction yields exactly one result transaction: it is held in
// the input register, then its decision is loaded into the result register. With no
// output stall, one transaction per cycle is sustained; the input register and
// the result register form a two-deep pipe set by the single decision stage.
// Reset (rst_n low) clears the transfer state to idle with zero count and
// empties both registers. A stall on the output holds the result register;
// the input register then holds too, and in_stall rises once it is full.
module i2c_master_transfer_sequencer_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic        bus_free,
    input  logic        direction,
    input  logic [6:0]  device_address,
    input  logic [7:0]  register_index,
    input  logic [15:0] byte_count,
    input  logic [7:0]  received_byte,
    input  logic [7:0]  next_tx_byte,

    output logic        out_valid,
    input  logic        out_stall,
    output logic        begin_accepted,
    output logic        send_valid,
    output logic [7:0]  send_byte,
    output logic        tx_consumed,
    output logic [1:0]  ack_control,
    output logic        issue_start,
    output logic        issue_stop,
    output logic        issue_restart,
    output logic        store_valid,
    output logic [7:0]  store_byte,
    output logic [1:0]  transfer_status
);

    logic              in_v_reg, in_v_next;
    i2cs_pkg::item_t   item_reg;
    logic              out_ready;
    logic              fire;
    logic              in_take;
    i2cs_pkg::result_t result;
    i2cs_pkg::result_t held;

    // Process the held item whenever the result register can take it.
    assign fire     = in_v_reg && out_ready;
    assign in_stall = in_v_reg && !out_ready;
    assign in_take  = in_valid && !in_stall;
    assign in_v_next = in_take || (in_v_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= in_v_next;
        end
    end

    // Capture the incoming transaction payload.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.op             <= op;
            item_reg.bus_free       <= bus_free;
            item_reg.direction      <= direction;
            item_reg.device_address <= device_address;
            item_reg.register_index <= register_index;
            item_reg.byte_count     <= byte_count;
            item_reg.received_byte  <= received_byte;
            item_reg.next_tx_byte   <= next_tx_byte;
        end
    end

    i2cs_event_logic u_event_logic
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .result (result)
    );

    i2cs_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .result    (result),
        .out_stall (out_stall),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .held      (held)
    );

    assign begin_accepted  = held.begin_accepted;
    assign send_valid      = held.send_valid;
    assign send_byte       = held.send_byte;
    assign tx_consumed     = held.tx_consumed;
    assign ack_control     = held.ack_control;
    assign issue_start     = held.issue_start;
    assign issue_stop      = held.issue_stop;
    assign issue_restart   = held.issue_restart;
    assign store_valid     = held.store_valid;
    assign store_byte      = held.store_byte;
    assign transfer_status = held.transfer_status;

    // Back-pressure on the input only arises from a full, stalled output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // A processed transaction shows up on the output in the next cycle.
    a_fire_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid)
        else $error("processed transaction missing at output");

    // An accepted transaction is held for processing in the next cycle.
    a_take_to_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_v_reg)
        else $error("accepted transaction lost");

endmodule

// ===== hw/rtl/i2cs_event_logic.sv =====
// Transfer state registers and the per-event decision logic.
module i2cs_event_logic
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  i2cs_pkg::item_t   item,
    output i2cs_pkg::result_t result
);

    logic [6:0]        device_reg, device_next;
    logic [7:0]        target_reg, target_next;
    logic              read_mode_reg, read_mode_next;
    logic [15:0]       bytes_left_reg, bytes_left_next;
    i2cs_pkg::status_t status_reg, status_next;

    logic [15:0] left_dec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_reg     <= '0;
            target_reg     <= '0;
            read_mode_reg  <= 1'b0;
            bytes_left_reg <= '0;
            status_reg     <= i2cs_pkg::ST_IDLE;
        end
        else if (fire)
        begin
            device_reg     <= device_next;
            target_reg     <= target_next;
            read_mode_reg  <= read_mode_next;
            bytes_left_reg <= bytes_left_next;
            status_reg     <= status_next;
        end
    end

    // Saturating decrement of the remaining byte count.
    assign left_dec = (bytes_left_reg != 16'd0) ? bytes_left_reg - 16'd1 : 16'd0;

    always_comb
    begin
        device_next     = device_reg;
        target_next     = target_reg;
        read_mode_next  = read_mode_reg;
        bytes_left_next = bytes_left_reg;
        status_next     = status_reg;
        result          = '0;

        unique case (i2cs_pkg::op_t'(item.op))
            i2cs_pkg::OP_BEGIN:
            begin
                if (item.bus_free)
                begin
                    device_next           = item.device_address;
                    target_next           = item.register_index;
                    read_mode_next        = item.direction;
                    bytes_left_next       = item.byte_count;
                    status_next           = i2cs_pkg::ST_BUSY;
                    result.begin_accepted = 1'b1;
                    result.ack_control    = i2cs_pkg::ACK_DISABLE;
                    result.issue_start    = 1'b1;
                end
            end
            i2cs_pkg::OP_START_SENT:
            begin
                result.send_valid = 1'b1;
                result.send_byte  = {device_reg, read_mode_reg};
            end
            i2cs_pkg::OP_ADDR_ACKED:
            begin
                priority if (!read_mode_reg)
                begin
                    result.send_valid = 1'b1;
                    result.send_byte  = target_reg;
                end
                else if (bytes_left_reg > 16'd1)
                begin
                    result.ack_control = i2cs_pkg::ACK_ENABLE;
                end
                else if (bytes_left_reg == 16'd1)
                begin
                    result.issue_stop = 1'b1;
                end
                else
                begin
                    result.issue_stop = 1'b1;
                    status_next       = i2cs_pkg::ST_DONE;
                end
            end
            i2cs_pkg::OP_BYTE_RECEIVED:
            begin
                bytes_left_next    = left_dec;
                result.store_valid = 1'b1;
                result.store_byte  = item.received_byte;
                if (left_dec == 16'd1)
                begin
                    result.ack_control = i2cs_pkg::ACK_DISABLE;
                    result.issue_stop  = 1'b1;
                end
                if (left_dec == 16'd0)
                begin
                    status_next = i2cs_pkg::ST_DONE;
                end
            end
            i2cs_pkg::OP_BYTE_SENT:
            begin
                if (bytes_left_reg != 16'd0)
                begin
                    result.send_valid  = 1'b1;
                    result.send_byte   = item.next_tx_byte;
                    result.tx_consumed = 1'b1;
                    bytes_left_next    = left_dec;
                end
                else
                begin
                    result.issue_stop = 1'b1;
                    status_next       = i2cs_pkg::ST_DONE;
                end
            end
            i2cs_pkg::OP_RESTART:
            begin
                result.issue_restart = 1'b1;
                result.issue_start   = (bytes_left_reg != 16'd0);
            end
            default:
            begin
            end
        endcase

        result.transfer_status = status_next;
    end

    // Only an accepted begin can raise the remaining byte count.
    a_count_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.op != i2cs_pkg::OP_BEGIN |=> bytes_left_reg <= $past(bytes_left_reg))
        else $error("byte count grew without a begin");

    // An accepted begin leaves the transfer busy.
    a_begin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.op == i2cs_pkg::OP_BEGIN && item.bus_free
        |=> status_reg == i2cs_pkg::ST_BUSY)
        else $error("begin did not mark the transfer busy");

    // A single event never both sends and stores a byte.
    a_send_store_excl: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !(result.send_valid && result.store_valid))
        else $error("send and store in the same event");

    // State only moves when an event is processed.
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(bytes_left_reg) && $stable(status_reg))
        else $error("state changed without an event");

endmodule

// ===== hw/rtl/i2cs_out_reg.sv =====
// Result register holding one transaction toward the consumer.
module i2cs_out_reg
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  i2cs_pkg::result_t result,
    input  logic              out_stall,
    output logic              out_ready,
    output logic              out_valid,
    output i2cs_pkg::result_t held
);

    logic              valid_reg, valid_next;
    i2cs_pkg::result_t data_reg;

    assign out_ready  = !valid_reg || !out_stall;
    assign valid_next = load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign held      = data_reg;

    // Never overwrite a result that the consumer has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && out_stall |-> !load)
        else $error("held result overwritten");

endmodule

// ===== tb/sv/tb_i2c_master_transfer_sequencer_core.sv =====
// Self-checking testbench for the I2C master transfer sequencer: directed and random bus-event traffic.
module tb_i2c_master_transfer_sequencer_core;

    // Op code 7 has no name in the package; the block treats it as no event.
    localparam logic [2:0] OP_UNUSED = 3'd7;

    // Cycles with no transaction on either side before the run is declared hung.
    localparam int QUIET_LIMIT = 1000;
    // Length of a long receiver hold-off, in cycles.
    localparam int HOLD_OFF_CYCLES = 80;
    // Number of mismatch lines printed before going quiet.
    localparam int REPORT_CAP = 40;
    // Number of input transactions to queue.
    localparam int ITEM_TARGET = 950;

    typedef struct {
        i2cs_pkg::item_t it;
        bit              drain_first;
    } pending_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  op = i2cs_pkg::OP_NONE;
    logic        bus_free = 1'b0;
    logic        direction = 1'b0;
    logic [6:0]  device_address = '0;
    logic [7:0]  register_index = '0;
    logic [15:0] byte_count = '0;
    logic [7:0]  received_byte = '0;
    logic [7:0]  next_tx_byte = '0;

    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        begin_accepted;
    logic        send_valid;
    logic [7:0]  send_byte;
    logic        tx_consumed;
    logic [1:0]  ack_control;
    logic        issue_start;
    logic        issue_stop;
    logic        issue_restart;
    logic        store_valid;
    logic [7:0]  store_byte;
    logic [1:0]  transfer_status;

    // Predictor copy of the transfer state.
    logic [7:0]        lat_addr = '0;
    logic [7:0]        lat_reg = '0;
    logic              lat_read = 1'b0;
    logic [15:0]       remain = '0;
    i2cs_pkg::status_t xfer_state = i2cs_pkg::ST_IDLE;

    pending_t          pending_q[$];
    i2cs_pkg::result_t bus_actions_due[$];

    // Transaction flags of the last rising edge, read by the falling-edge processes.
    logic        in_taken = 1'b0;
    logic        out_taken = 1'b0;

    int          errors = 0;
    int          accepted_items = 0;
    int          results_seen = 0;
    int          op_seen[8];
    int          stim_events = 0;
    bit          drain_next = 1'b0;
    int          drains = 0;
    int          holds = 0;

    i2c_master_transfer_sequencer_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .bus_free        (bus_free),
        .direction       (direction),
        .device_address  (device_address),
        .register_index  (register_index),
        .byte_count      (byte_count),
        .received_byte   (received_byte),
        .next_tx_byte    (next_tx_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .begin_accepted  (begin_accepted),
        .send_valid      (send_valid),
        .send_byte       (send_byte),
        .tx_consumed     (tx_consumed),
        .ack_control     (ack_control),
        .issue_start     (issue_start),
        .issue_stop      (issue_stop),
        .issue_restart   (issue_restart),
        .store_valid     (store_valid),
        .store_byte      (store_byte),
        .transfer_status (transfer_status)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: apply one bus event to the modeled state and return the
    // bus actions it calls for.
    // ------------------------------------------------------------------
    function automatic i2cs_pkg::result_t next_bus_actions(input i2cs_pkg::item_t it);
        i2cs_pkg::result_t r;
        r = '0;
        case (it.op)
            i2cs_pkg::OP_BEGIN:
            begin
                // A free bus relatches everything, whatever the current status.
                if (it.bus_free)
                begin
                    lat_addr = {it.device_address, 1'b0};
                    lat_reg = it.register_index;
                    lat_read = it.direction;
                    remain = it.byte_count;
                    xfer_state = i2cs_pkg::ST_BUSY;
                    r.begin_accepted = 1'b1;
                    r.ack_control = i2cs_pkg::ACK_DISABLE;
                    r.issue_start = 1'b1;
                end
            end
            i2cs_pkg::OP_START_SENT:
            begin
                r.send_valid = 1'b1;
                r.send_byte = lat_addr | {7'd0, lat_read};
            end
            i2cs_pkg::OP_ADDR_ACKED:
            begin
                if (!lat_read)
                begin
                    r.send_valid = 1'b1;
                    r.send_byte = lat_reg;
                end
                else if (remain > 16'd1)
                    r.ack_control = i2cs_pkg::ACK_ENABLE;
                else if (remain == 16'd1)
                    r.issue_stop = 1'b1;
                else
                begin
                    r.issue_stop = 1'b1;
                    xfer_state = i2cs_pkg::ST_DONE;
                end
            end
            i2cs_pkg::OP_BYTE_RECEIVED:
            begin
                // Count saturates at zero.
                if (remain != 16'd0)
                    remain = remain - 16'd1;
                if (remain == 16'd1)
                begin
                    r.ack_control = i2cs_pkg::ACK_DISABLE;
                    r.issue_stop = 1'b1;
                end
                if (remain == 16'd0)
                    xfer_state = i2cs_pkg::ST_DONE;
                r.store_valid = 1'b1;
                r.store_byte = it.received_byte;
            end
            i2cs_pkg::OP_BYTE_SENT:
            begin
                if (remain != 16'd0)
                begin
                    r.send_valid = 1'b1;
                    r.send_byte = it.next_tx_byte;
                    r.tx_consumed = 1'b1;
                    remain = remain - 16'd1;
                end
                else
                begin
                    r.issue_stop = 1'b1;
                    xfer_state = i2cs_pkg::ST_DONE;
                end
            end
            i2cs_pkg::OP_RESTART:
            begin
                r.issue_restart = 1'b1;
                if (remain != 16'd0)
                    r.issue_start = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.transfer_status = xfer_state;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus construction
    // ------------------------------------------------------------------
    // Fully random item; every bit of every field toggles across the run.
    function automatic i2cs_pkg::item_t noise_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(i2cs_pkg::item_t)-1:0];
    endfunction

    // Bus event with random don't-care fields.
    function automatic i2cs_pkg::item_t event_item(input logic [2:0] code);
        i2cs_pkg::item_t it;
        it = noise_item();
        it.op = code;
        return it;
    endfunction

    function automatic i2cs_pkg::item_t begin_item(input logic rd, input logic [6:0] dev,
                                                   input logic [7:0] regi,
                                                   input logic [15:0] cnt);
        i2cs_pkg::item_t it;
        it = event_item(i2cs_pkg::OP_BEGIN);
        it.bus_free = 1'b1;
        it.direction = rd;
        it.device_address = dev;
        it.register_index = regi;
        it.byte_count = cnt;
        return it;
    endfunction

    task automatic queue_item(input i2cs_pkg::item_t it);
        pending_t p;
        p.it = it;
        p.drain_first = drain_next;
        drain_next = 1'b0;
        pending_q.push_back(p);
        // Idle events and refused begins leave the state alone; don't count them.
        if (!(it.op == i2cs_pkg::OP_NONE || it.op == OP_UNUSED ||
              (it.op == i2cs_pkg::OP_BEGIN && !it.bus_free)))
            stim_events++;
    endtask

    task automatic directed_items();
        i2cs_pkg::item_t it;
        // Events straight out of reset, with nothing latched.
        queue_item(event_item(i2cs_pkg::OP_START_SENT));
        queue_item(event_item(i2cs_pkg::OP_ADDR_ACKED));
        queue_item(event_item(i2cs_pkg::OP_BYTE_RECEIVED));
        queue_item(event_item(i2cs_pkg::OP_BYTE_SENT));
        queue_item(event_item(i2cs_pkg::OP_RESTART));
        queue_item(event_item(i2cs_pkg::OP_NONE));
        queue_item(event_item(OP_UNUSED));
        // Begin with the bus busy is refused.
        it = begin_item(1'b0, 7'h7F, 8'hFF, 16'hFFFF);
        it.bus_free = 1'b0;
        queue_item(it);
        // Write of one byte at the highest address and register.
        queue_item(begin_item(1'b0, 7'h7F, 8'hFF, 16'd1));
        queue_item(event_item(i2cs_pkg::OP_START_SENT));
        queue_item(event_item(i2cs_pkg::OP_ADDR_ACKED));
        it = event_item(i2cs_pkg::OP_BYTE_SENT);
        it.next_tx_byte = 8'hFF;
        queue_item(it);
        queue_item(event_item(i2cs_pkg::OP_BYTE_SENT));
        // Read of two bytes at address zero, begun while done; restart in the middle.
        queue_item(begin_item(1'b1, 7'h00, 8'h00, 16'd2));
        queue_item(event_item(i2cs_pkg::OP_START_SENT));
        queue_item(event_item(i2cs_pkg::OP_ADDR_ACKED));
        queue_item(event_item(i2cs_pkg::OP_RESTART));
        it = event_item(i2cs_pkg::OP_BYTE_RECEIVED);
        it.received_byte = 8'hFF;
        queue_item(it);
        it = event_item(i2cs_pkg::OP_BYTE_RECEIVED);
        it.received_byte = 8'h00;
        queue_item(it);
        // Reads of one and of zero bytes stop right after the address.
        queue_item(begin_item(1'b1, 7'h55, 8'hAA, 16'd1));
        queue_item(event_item(i2cs_pkg::OP_ADDR_ACKED));
        queue_item(begin_item(1'b1, 7'h2A, 8'h55, 16'd0));
        queue_item(event_item(i2cs_pkg::OP_ADDR_ACKED));
        // Largest count, then relatch while busy with a zero count.
        queue_item(begin_item(1'b0, 7'h01, 8'h80, 16'hFFFF));
        queue_item(begin_item(1'b0, 7'h40, 8'h01, 16'd0));
        queue_item(event_item(i2cs_pkg::OP_BYTE_SENT));
    endtask

    // Well-formed transfer with random content; mostly short counts.
    task automatic random_transfer();
        logic        rd;
        int          n;
        int          steps;
        rd = 1'($urandom_range(0, 1));
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 6);
        queue_item(begin_item(rd, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                              16'(n)));
        queue_item(event_item(i2cs_pkg::OP_START_SENT));
        queue_item(event_item(i2cs_pkg::OP_ADDR_ACKED));
        // Writes need one extra byte-sent event to reach STOP; reads sometimes overrun.
        steps = ((n > 8) ? 8 : n) + (rd ? $urandom_range(0, 1) : 1);
        for (int k = 0; k < steps; k++)
        begin
            if ($urandom_range(0, 15) == 0)
                queue_item(event_item(i2cs_pkg::OP_RESTART));
            if ($urandom_range(0, 15) == 0)
                queue_item(event_item(i2cs_pkg::OP_NONE));
            queue_item(event_item(rd ? i2cs_pkg::OP_BYTE_RECEIVED : i2cs_pkg::OP_BYTE_SENT));
        end
    endtask

    task automatic build_stimulus();
        i2cs_pkg::item_t it;
        int              pick;
        int              next_drain_at;
        directed_items();
        next_drain_at = stim_events + 200;
        while (pending_q.size() < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 6)
                random_transfer();
            else if (pick == 7)
            begin
                // Pure noise: any op, including the unused code.
                repeat ($urandom_range(1, 3))
                    queue_item(noise_item());
            end
            else if (pick == 8)
            begin
                it = event_item(i2cs_pkg::OP_BEGIN);
                it.bus_free = 1'b0;
                queue_item(it);
                queue_item(event_item(i2cs_pkg::OP_RESTART));
            end
            else
            begin
                // Broken transfer: begin, then a random handful of events.
                it = event_item(i2cs_pkg::OP_BEGIN);
                it.bus_free = 1'b1;
                queue_item(it);
                repeat ($urandom_range(1, 4))
                    queue_item(event_item(3'($urandom_range(i2cs_pkg::OP_START_SENT,
                                                            i2cs_pkg::OP_RESTART))));
            end
            // Periodically make the sender wait for the pipe to empty.
            if (stim_events >= next_drain_at)
            begin
                drain_next = 1'b1;
                next_drain_at = next_drain_at + 200;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: present pending items at the falling edge. Hold the payload
    // while stalled; after each transaction idle a random number of cycles,
    // none at all in one burst window.
    // ------------------------------------------------------------------
    int       gap_left = 0;
    pending_t cur;

    always @(negedge clk)
    begin
        logic offer;
        if (rst_n)
        begin
            offer = in_valid && !in_taken;
            if (in_taken)
                gap_left = (accepted_items >= 400 && accepted_items < 480) ?
                           0 : $urandom_range(0, 12);
            if (!offer)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_q.size() != 0 &&
                         !(pending_q[0].drain_first && bus_actions_due.size() != 0))
                begin
                    // A marked item waits until every outstanding result is back.
                    if (pending_q[0].drain_first)
                        drains++;
                    cur = pending_q.pop_front();
                    op <= cur.it.op;
                    bus_free <= cur.it.bus_free;
                    direction <= cur.it.direction;
                    device_address <= cur.it.device_address;
                    register_index <= cur.it.register_index;
                    byte_count <= cur.it.byte_count;
                    received_byte <= cur.it.received_byte;
                    next_tx_byte <= cur.it.next_tx_byte;
                    offer = 1'b1;
                end
            end
            in_valid <= offer;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall each result for a random count of cycles, none in one
    // window, and twice hold off for a long stretch so the block backs up.
    // ------------------------------------------------------------------
    int stall_left = 0;
    int hold_left = 0;
    int next_hold_at = 250;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_taken)
                stall_left = (results_seen >= 390 && results_seen < 490) ?
                             0 : $urandom_range(0, 12);
            if (results_seen >= next_hold_at)
            begin
                hold_left = HOLD_OFF_CYCLES;
                next_hold_at = next_hold_at + 400;
                holds++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (out_valid && stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at the rising edge, predict each accepted transaction and
    // check each result transaction against the oldest prediction.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            if (errors < REPORT_CAP)
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        i2cs_pkg::item_t   seen;
        i2cs_pkg::result_t want;
        i2cs_pkg::result_t got;
        if (rst_n)
        begin
            in_taken <= in_valid && !in_stall;
            out_taken <= out_valid && !out_stall;
            if (in_valid && !in_stall)
            begin
                seen.op = op;
                seen.bus_free = bus_free;
                seen.direction = direction;
                seen.device_address = device_address;
                seen.register_index = register_index;
                seen.byte_count = byte_count;
                seen.received_byte = received_byte;
                seen.next_tx_byte = next_tx_byte;
                bus_actions_due.push_back(next_bus_actions(seen));
                op_seen[op]++;
                accepted_items++;
            end
            if (out_valid && !out_stall)
            begin
                got = {begin_accepted, send_valid, send_byte, tx_consumed, ack_control,
                       issue_start, issue_stop, issue_restart, store_valid, store_byte,
                       transfer_status};
                results_seen++;
                if (bus_actions_due.size() == 0)
                begin
                    if (errors < REPORT_CAP)
                        $display("%0t: result with nothing expected: expected none, actual %0h",
                                 $time, got);
                    errors++;
                end
                else
                begin
                    want = bus_actions_due.pop_front();
                    check_field("begin_accepted", 16'(want.begin_accepted),
                                16'(got.begin_accepted));
                    check_field("send_valid", 16'(want.send_valid), 16'(got.send_valid));
                    check_field("send_byte", 16'(want.send_byte), 16'(got.send_byte));
                    check_field("tx_consumed", 16'(want.tx_consumed), 16'(got.tx_consumed));
                    check_field("ack_control", 16'(want.ack_control), 16'(got.ack_control));
                    check_field("issue_start", 16'(want.issue_start), 16'(got.issue_start));
                    check_field("issue_stop", 16'(want.issue_stop), 16'(got.issue_stop));
                    check_field("issue_restart", 16'(want.issue_restart),
                                16'(got.issue_restart));
                    check_field("store_valid", 16'(want.store_valid), 16'(got.store_valid));
                    check_field("store_byte", 16'(want.store_byte), 16'(got.store_byte));
                    check_field("transfer_status", 16'(want.transfer_status),
                                16'(got.transfer_status));
                end
            end
        end
    end

    // Watchdog: count cycles in which neither side completes a transaction.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence the run: build stimulus, release reset, wait for the driver
    // to empty its queue and for every result, then report.
    // ------------------------------------------------------------------
    initial
    begin
        build_stimulus();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        while (pending_q.size() != 0 || in_valid)
            @(posedge clk);
        while (bus_actions_due.size() != 0)
            @(posedge clk);
        // Let any stray result surface; the pipe is two deep.
        repeat (10) @(posedge clk);
        if (bus_actions_due.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, bus_actions_due.size());
            errors++;
        end
        $display("Run covered %0d transactions (begins %0d, reads %0d, writes %0d, restarts %0d)",
                 accepted_items, op_seen[i2cs_pkg::OP_BEGIN],
                 op_seen[i2cs_pkg::OP_BYTE_RECEIVED], op_seen[i2cs_pkg::OP_BYTE_SENT],
                 op_seen[i2cs_pkg::OP_RESTART]);
        $display("and checked %0d results through %0d long hold-offs and %0d pipe drains",
                 results_seen, holds, drains);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/i2cs_pkg.sv
hw/rtl/i2cs_event_logic.sv
hw/rtl/i2cs_out_reg.sv
hw/rtl/i2c_master_transfer_sequencer_core.sv
tb/sv/tb_i2c_master_transfer_sequencer_core.sv
